/* sv/brc_pkg.sv */
// Shared types, widths and the per-axis clip function for the blit rectangle clipper.
// Used by the channel interfaces, brc_dclip, brc_emit and the top level.
`default_nettype none

package brc_pkg;

  localparam int COORD_BITS = 18;   // result coordinate width, range 12..32
  localparam int IW         = 21;   // internal signed width, holds every intermediate value
  localparam int IN_CW      = 17;   // request coordinate width
  localparam int SIZE_W     = 16;
  localparam int FRAME_W    = 16;
  localparam int NUM_SLOTS  = 5;    // copy, then top, bottom, left, right fills
  localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [IW-1:0]         inner_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [IN_CW-1:0]      in_coord_t;
  typedef logic        [SIZE_W-1:0]     size_t;

  typedef enum logic [1:0] {
    OP_COPY       = 2'd0,
    OP_FILL_SET   = 2'd1,
    OP_FILL_CLEAR = 2'd2,
    OP_FILL_BG    = 2'd3
  } op_kind_e;

  typedef enum logic [1:0] {
    RM_COPY  = 2'd0,
    RM_SET   = 2'd1,
    RM_CLEAR = 2'd2
  } raster_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_X = 3'd0,
    CFG_SRC_Y = 3'd1,
    CFG_SRC_W = 3'd2,
    CFG_SRC_H = 3'd3,
    CFG_DST_X = 3'd4,
    CFG_DST_Y = 3'd5,
    CFG_DST_W = 3'd6,
    CFG_DST_H = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SOLID = 2'd1,
    KIND_COPY  = 2'd2
  } item_kind_e;

  typedef struct packed {
    logic signed [FRAME_W-1:0] src_x;
    logic signed [FRAME_W-1:0] src_y;
    logic        [FRAME_W-1:0] src_w;
    logic        [FRAME_W-1:0] src_h;
    logic signed [FRAME_W-1:0] dst_x;
    logic signed [FRAME_W-1:0] dst_y;
    logic        [FRAME_W-1:0] dst_w;
    logic        [FRAME_W-1:0] dst_h;
  } cfg_t;

  typedef struct packed {
    in_coord_t  source_x;
    in_coord_t  source_y;
    size_t      copy_width;
    size_t      copy_height;
    in_coord_t  dest_x;
    in_coord_t  dest_y;
    logic [1:0] raster_mode;
    logic       dest_is_window;
  } req_t;

  // Request after frame offsets and destination clip
  typedef struct packed {
    item_kind_e kind;
    op_kind_e   fill_op;
    logic       win;
    logic       clipped;
    inner_t     sx;
    inner_t     sy;
    inner_t     dx;
    inner_t     dy;
    inner_t     w;
    inner_t     h;
  } dclip_t;

  typedef struct packed {
    op_kind_e op;
    coord_t   x;
    coord_t   y;
    size_t    w;
    size_t    h;
    coord_t   fx;
    coord_t   fy;
  } rect_t;

  typedef struct packed {
    inner_t pos;
    inner_t other;
    inner_t len;
    logic   clip;
  } axis_t;

  // Clip one axis against [0, lim); the other rectangle's corner moves along.
  function automatic axis_t clip_axis(inner_t pos, inner_t other, inner_t len, inner_t lim);
    axis_t  r;
    inner_t over;
    r.pos   = pos;
    r.other = other;
    r.len   = len;
    r.clip  = 1'b0;
    if (pos < 0) begin
      r.clip  = 1'b1;
      r.len   = len + pos;
      r.other = other - pos;
      r.pos   = '0;
    end
    over = r.pos + r.len - lim;
    if (over > 0) begin
      r.clip = 1'b1;
      r.len  = lim - r.pos;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/brc_req_if.sv */
// Request channel: one area-copy request per transfer.
// Depends on brc_pkg for field widths.
`default_nettype none

interface brc_req_if;
  logic                    valid;
  logic                    ready;
  brc_pkg::in_coord_t      source_x;
  brc_pkg::in_coord_t      source_y;
  brc_pkg::size_t          copy_width;
  brc_pkg::size_t          copy_height;
  brc_pkg::in_coord_t      dest_x;
  brc_pkg::in_coord_t      dest_y;
  logic [1:0]              raster_mode;
  logic                    dest_is_window;

  modport source (
    output valid, source_x, source_y, copy_width, copy_height, dest_x, dest_y,
           raster_mode, dest_is_window,
    input  ready
  );
  modport sink (
    input  valid, source_x, source_y, copy_width, copy_height, dest_x, dest_y,
           raster_mode, dest_is_window,
    output ready
  );
endinterface

`default_nettype wire

/* sv/brc_rsp_if.sv */
// Result channel: one rectangle command per transfer.
// Depends on brc_pkg for field widths and the op kind codes.
`default_nettype none

interface brc_rsp_if;
  logic               valid;
  logic               ready;
  brc_pkg::op_kind_e  op_kind;
  brc_pkg::coord_t    rect_x;
  brc_pkg::coord_t    rect_y;
  brc_pkg::size_t     rect_width;
  brc_pkg::size_t     rect_height;
  brc_pkg::coord_t    from_x;
  brc_pkg::coord_t    from_y;
  logic               last;

  modport source (
    output valid, op_kind, rect_x, rect_y, rect_width, rect_height, from_x, from_y, last,
    input  ready
  );
  modport sink (
    input  valid, op_kind, rect_x, rect_y, rect_width, rect_height, from_x, from_y, last,
    output ready
  );
endinterface

`default_nettype wire

/* sv/brc_dclip.sv */
// Input register and destination clip stage: frame offsets, clip against the
// destination frame, classify the request. Depends on brc_pkg and brc_req_if.
`default_nettype none

module brc_dclip (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  brc_req_if.sink            req,
  input  wire brc_pkg::cfg_t cfg_i,
  output brc_pkg::dclip_t    dc_o,
  output logic               dc_valid_o,
  input  wire logic          dc_ready_i
);
  import brc_pkg::*;

  logic   in_valid_q;
  req_t   in_q;
  logic   in_ready;
  logic   dc_valid_q;
  dclip_t dc_q;
  dclip_t dc_d;
  logic   dc_ready;

  inner_t sx0, sy0, dx0, dy0, w0, h0, lim_x, lim_y;
  axis_t  ax, ay;
  logic   zero_size, solid;

  assign dc_ready = !dc_valid_q || dc_ready_i;
  assign in_ready = !in_valid_q || dc_ready;
  assign req.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      dc_valid_q <= 1'b0;
    end else begin
      if (in_ready) in_valid_q <= req.valid;
      if (dc_ready) dc_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req.valid) begin
      in_q.source_x       <= req.source_x;
      in_q.source_y       <= req.source_y;
      in_q.copy_width     <= req.copy_width;
      in_q.copy_height    <= req.copy_height;
      in_q.dest_x         <= req.dest_x;
      in_q.dest_y         <= req.dest_y;
      in_q.raster_mode    <= req.raster_mode;
      in_q.dest_is_window <= req.dest_is_window;
    end
    if (dc_ready && in_valid_q) dc_q <= dc_d;
  end

  assign sx0   = inner_t'(in_q.source_x) + inner_t'(cfg_i.src_x);
  assign sy0   = inner_t'(in_q.source_y) + inner_t'(cfg_i.src_y);
  assign dx0   = inner_t'(in_q.dest_x) + inner_t'(cfg_i.dst_x);
  assign dy0   = inner_t'(in_q.dest_y) + inner_t'(cfg_i.dst_y);
  assign w0    = inner_t'(in_q.copy_width);
  assign h0    = inner_t'(in_q.copy_height);
  assign lim_x = inner_t'(cfg_i.dst_x) + inner_t'(cfg_i.dst_w);
  assign lim_y = inner_t'(cfg_i.dst_y) + inner_t'(cfg_i.dst_h);

  assign ax = clip_axis(dx0, sx0, w0, lim_x);
  assign ay = clip_axis(dy0, sy0, h0, lim_y);

  assign zero_size = (in_q.copy_width == '0) || (in_q.copy_height == '0);
  assign solid     = (in_q.raster_mode == RM_SET) || (in_q.raster_mode == RM_CLEAR);

  always_comb begin
    dc_d.win     = in_q.dest_is_window;
    dc_d.clipped = ax.clip | ay.clip;
    dc_d.fill_op = (in_q.raster_mode == RM_SET) ? OP_FILL_SET : OP_FILL_CLEAR;
    dc_d.sx      = ax.other;
    dc_d.sy      = ay.other;
    dc_d.dx      = ax.pos;
    dc_d.dy      = ay.pos;
    dc_d.w       = ax.len;
    dc_d.h       = ay.len;
    if (zero_size) begin
      dc_d.kind = KIND_NONE;
    end else if (solid) begin
      // solid fill covers the request as given, no offset or clip
      dc_d.kind = KIND_SOLID;
      dc_d.dx   = inner_t'(in_q.dest_x);
      dc_d.dy   = inner_t'(in_q.dest_y);
      dc_d.w    = w0;
      dc_d.h    = h0;
    end else if (ax.len <= 0 || ay.len <= 0) begin
      dc_d.kind = KIND_NONE;
    end else begin
      dc_d.kind = KIND_COPY;
    end
  end

  assign dc_o       = dc_q;
  assign dc_valid_o = dc_valid_q;

endmodule

`default_nettype wire

/* sv/brc_emit.sv */
// Source clip, result list build and the result buffer that hands out one
// rectangle command per transfer. Depends on brc_pkg and brc_rsp_if.
`default_nettype none

module brc_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire brc_pkg::cfg_t   cfg_i,
  input  wire brc_pkg::dclip_t dc_i,
  input  wire logic            dc_valid_i,
  output logic                 dc_ready_o,
  brc_rsp_if.source            rsp
);
  import brc_pkg::*;

  localparam int SLOT_COPY   = 0;
  localparam int SLOT_TOP    = 1;
  localparam int SLOT_BOTTOM = 2;
  localparam int SLOT_LEFT   = 3;
  localparam int SLOT_RIGHT  = 4;

  function automatic rect_t mk_rect(op_kind_e op, inner_t x, inner_t y, inner_t w,
                                    inner_t h, inner_t fx, inner_t fy);
    rect_t r;
    r.op = op;
    r.x  = COORD_BITS'(x);
    r.y  = COORD_BITS'(y);
    r.w  = w[SIZE_W-1:0];
    r.h  = h[SIZE_W-1:0];
    r.fx = COORD_BITS'(fx);
    r.fy = COORD_BITS'(fy);
    return r;
  endfunction

  rect_t                  slots_q [NUM_SLOTS];
  rect_t                  slots_d [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   mask_q;
  logic [NUM_SLOTS-1:0]   mask_d;
  logic [NUM_SLOTS-1:0]   sel;
  logic [SLOT_IDX_W-1:0]  idx;
  logic                   is_last;
  logic                   take;
  logic                   load;

  inner_t lim_x, lim_y, wf, hf, dx1, dy1, dbot, dright;
  axis_t  bx, by;
  logic   copy_ok, fill_en;

  assign lim_x = inner_t'(cfg_i.src_x) + inner_t'(cfg_i.src_w);
  assign lim_y = inner_t'(cfg_i.src_y) + inner_t'(cfg_i.src_h);

  assign bx = clip_axis(dc_i.sx, dc_i.dx, dc_i.w, lim_x);
  assign by = clip_axis(dc_i.sy, dc_i.dy, dc_i.h, lim_y);

  assign copy_ok = (bx.len > 0) && (by.len > 0);
  assign dx1     = bx.other;
  assign dy1     = by.other;
  // strips use zero copy size when the source clip leaves nothing
  assign wf      = copy_ok ? bx.len : '0;
  assign hf      = copy_ok ? by.len : '0;
  assign dbot    = dy1 + hf;
  assign dright  = dx1 + wf;
  assign fill_en = (dc_i.kind == KIND_COPY) && dc_i.win && (dc_i.clipped | bx.clip | by.clip);

  always_comb begin
    if (dc_i.kind == KIND_SOLID) begin
      slots_d[SLOT_COPY] = mk_rect(dc_i.fill_op, dc_i.dx, dc_i.dy, dc_i.w, dc_i.h, '0, '0);
    end else begin
      slots_d[SLOT_COPY] = mk_rect(OP_COPY, dx1, dy1, bx.len, by.len, bx.pos, by.pos);
    end
    slots_d[SLOT_TOP]    = mk_rect(OP_FILL_BG, dc_i.dx, dc_i.dy, dc_i.w,
                                   dy1 - dc_i.dy, '0, '0);
    slots_d[SLOT_BOTTOM] = mk_rect(OP_FILL_BG, dc_i.dx, dbot, dc_i.w,
                                   dc_i.dy + dc_i.h - dbot, '0, '0);
    slots_d[SLOT_LEFT]   = mk_rect(OP_FILL_BG, dc_i.dx, dy1, dx1 - dc_i.dx, hf, '0, '0);
    slots_d[SLOT_RIGHT]  = mk_rect(OP_FILL_BG, dright, dy1,
                                   dc_i.dx + dc_i.w - dright, hf, '0, '0);

    mask_d[SLOT_COPY]   = (dc_i.kind == KIND_SOLID) || ((dc_i.kind == KIND_COPY) && copy_ok);
    mask_d[SLOT_TOP]    = fill_en && (dc_i.dy < dy1);
    mask_d[SLOT_BOTTOM] = fill_en && (dc_i.dy + dc_i.h > dbot);
    mask_d[SLOT_LEFT]   = fill_en && (dc_i.dx < dx1);
    mask_d[SLOT_RIGHT]  = fill_en && (dright < dc_i.dx + dc_i.w);
  end

  // pending results go out lowest slot first
  assign sel = mask_q & (~mask_q + NUM_SLOTS'(1));

  always_comb begin
    idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel[i]) idx = SLOT_IDX_W'(i);
    end
  end

  assign is_last    = ((mask_q & ~sel) == '0);
  assign take       = (mask_q == '0) || (rsp.ready && is_last);
  assign load       = dc_valid_i && take;
  assign dc_ready_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (load) begin
      mask_q <= mask_d;
    end else if (rsp.valid && rsp.ready) begin
      mask_q <= mask_q & ~sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < NUM_SLOTS; i++) slots_q[i] <= slots_d[i];
    end
  end

  assign rsp.valid       = |mask_q;
  assign rsp.op_kind     = slots_q[idx].op;
  assign rsp.rect_x      = slots_q[idx].x;
  assign rsp.rect_y      = slots_q[idx].y;
  assign rsp.rect_width  = slots_q[idx].w;
  assign rsp.rect_height = slots_q[idx].h;
  assign rsp.from_x      = slots_q[idx].fx;
  assign rsp.from_y      = slots_q[idx].fy;
  assign rsp.last        = is_last;

endmodule

`default_nettype wire

/* sv/blit_rectangle_clipper.sv */
// Blit rectangle clipper top level: frame registers, clip pipeline, result buffer.
// Depends on brc_pkg, brc_req_if, brc_rsp_if, brc_dclip and brc_emit.
// Path to the first result: input register, clip register, result buffer.
// Throughput: one request per cycle while rsp.ready holds and each gives at most one
// result; a request with up to five results holds the buffer, one result per transfer.
// Reset clears all valid state and the frame registers to zero; no clearing pass.
`default_nettype none

module blit_rectangle_clipper (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  brc_req_if.sink                                req,
  brc_rsp_if.source                              rsp,
  input  wire logic                              cfg_we_i,
  input  wire logic [brc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [brc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import brc_pkg::*;

  cfg_t   cfg_q;
  dclip_t dc;
  logic   dc_valid;
  logic   dc_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SRC_X: cfg_q.src_x <= cfg_wdata_i;
        CFG_SRC_Y: cfg_q.src_y <= cfg_wdata_i;
        CFG_SRC_W: cfg_q.src_w <= cfg_wdata_i;
        CFG_SRC_H: cfg_q.src_h <= cfg_wdata_i;
        CFG_DST_X: cfg_q.dst_x <= cfg_wdata_i;
        CFG_DST_Y: cfg_q.dst_y <= cfg_wdata_i;
        CFG_DST_W: cfg_q.dst_w <= cfg_wdata_i;
        CFG_DST_H: cfg_q.dst_h <= cfg_wdata_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  brc_dclip u_dclip (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .cfg_i      (cfg_q),
    .dc_o       (dc),
    .dc_valid_o (dc_valid),
    .dc_ready_i (dc_ready)
  );

  brc_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .dc_i       (dc),
    .dc_valid_i (dc_valid),
    .dc_ready_o (dc_ready),
    .rsp        (rsp)
  );

`ifndef SYNTHESIS
  a_solid_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && (rsp.op_kind == OP_FILL_SET || rsp.op_kind == OP_FILL_CLEAR) |-> rsp.last)
    else $error("solid fill not the only result of its request");

  a_fill_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.op_kind != OP_COPY |-> rsp.from_x == '0 && rsp.from_y == '0)
    else $error("fill result carries a source corner");

  a_copy_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.op_kind == OP_COPY |-> rsp.rect_width != '0 && rsp.rect_height != '0)
    else $error("empty copy rectangle emitted");

  a_copy_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.ready && !rsp.last && rsp.op_kind == OP_FILL_BG
    |=> !(rsp.valid && rsp.op_kind == OP_COPY))
    else $error("copy result after a background fill of the same request");
`endif

endmodule

`default_nettype wire
